// File: design/priority_ready_queue_assert.svh
// Assertion macros for the priority ready queue.
// Included by the top level; depends on nothing else.
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define PRQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define PRQ_ASSERT_IMPL(label, clk, rst_n, cause, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (conseq)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define PRQ_ASSERT_NEXT(label, clk, rst_n, cause, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (conseq)) \
        else $error(msg);

`else

`define PRQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define PRQ_ASSERT_IMPL(label, clk, rst_n, cause, conseq, msg)
`define PRQ_ASSERT_NEXT(label, clk, rst_n, cause, conseq, msg)

`endif

`endif

// File: design/prq_pkg.sv
// Shared types, codes and default sizes of the priority ready queue.
// Depends on nothing; the controller, datapath, top level and testbench import it.
package prq_pkg;

    localparam int DEF_NUM_LEVELS  = 8;
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_NUM_TASKS   = 16;

    localparam int KIND_W   = 2;
    localparam int TASK_FW  = 4;
    localparam int PRIO_FW  = 3;
    localparam int PC_W     = 16;
    localparam int ORDER_W  = 8;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = TASK_FW + PC_W + ORDER_W;

    localparam logic [KIND_W-1:0] KIND_NEW     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREEMPT = 2'd1;
    localparam int                KIND_POP_BIT = 1;

    localparam logic [STATUS_W-1:0] ST_PUSHED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE_TASK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TASK_FW-1:0] task_id;
        logic [PRIO_FW-1:0] prio;
        logic [PC_W-1:0]    pc;
        logic               sleepers_present;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_FW-1:0]  out_task;
        logic [PRIO_FW-1:0]  out_prio;
        logic [PC_W-1:0]     out_pc;
        logic [ORDER_W-1:0]  out_activation;
        logic [PRIO_FW-1:0]  highest_ready;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic queue_empty;
        logic top_ok;
    } t_dp_status;

endpackage

// File: design/prq_stream_if.sv
// Valid/ready channel carrying one request of payload type T.
// Depends on nothing; the payload type is given where it is instantiated.
interface prq_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/prq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/prq_ctrl.sv
// Controller of the priority ready queue: accept, commit and output handshake.
// Depends on prq_pkg.
module prq_ctrl import prq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic commit;

    // The result may only be committed once the output register is free.
    assign commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.commit  = commit;
endmodule

// File: design/prq_datapath.sv
// Datapath of the priority ready queue: level pointers, counts, activation
// counters, queue RAM and the result register. Depends on prq_pkg, prq_ram.
module prq_datapath import prq_pkg::*; #(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int NUM_TASKS   = DEF_NUM_TASKS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_req       i_req,
    output t_rsp       o_rsp,
    output t_dp_status o_status
);
    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(LEVEL_DEPTH);
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int TASK_W  = $clog2(NUM_TASKS);
    localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int LEXT_W  = (LVL_W > PRIO_FW) ? LVL_W : PRIO_FW;
    localparam int TEXT_W  = (TASK_W > TASK_FW) ? TASK_W : TASK_FW;

    function automatic logic [LVL_W-1:0] lvl_of(input logic [PRIO_FW-1:0] p);
        logic [LEXT_W-1:0] e;
        e = LEXT_W'(p);
        return e[LVL_W-1:0];
    endfunction

    function automatic logic [PRIO_FW-1:0] prio_of(input logic [LVL_W-1:0] l);
        logic [LEXT_W-1:0] e;
        e = LEXT_W'(l);
        return e[PRIO_FW-1:0];
    endfunction

    function automatic logic [TASK_W-1:0] tidx_of(input logic [TASK_FW-1:0] t);
        logic [TEXT_W-1:0] e;
        e = TEXT_W'(t);
        return e[TASK_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_of(input logic [LVL_W-1:0] l,
                                                  input logic [PTR_W-1:0] p);
        return ADDR_W'(32'(l) * LEVEL_DEPTH + 32'(p));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Highest set bit, or level zero when none is set.
    function automatic logic [LVL_W-1:0] top_of(input logic [NUM_LEVELS-1:0] v);
        logic [LVL_W-1:0] res;
        res = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (v[i]) begin
                res = LVL_W'(i);
            end
        end
        return res;
    endfunction

    logic [PTR_W-1:0]   r_head [NUM_LEVELS];
    logic [PTR_W-1:0]   n_head [NUM_LEVELS];
    logic [PTR_W-1:0]   r_tail [NUM_LEVELS];
    logic [PTR_W-1:0]   n_tail [NUM_LEVELS];
    logic [CNT_W-1:0]   r_count [NUM_LEVELS];
    logic [CNT_W-1:0]   n_count [NUM_LEVELS];
    logic [LVL_W-1:0]   r_top, n_top;
    logic [ORDER_W-1:0] r_next_act [NUM_TASKS];
    logic [ORDER_W-1:0] n_next_act [NUM_TASKS];
    logic [ORDER_W-1:0] r_cur_act [NUM_TASKS];
    logic [ORDER_W-1:0] n_cur_act [NUM_TASKS];
    t_req               r_req;
    t_rsp               r_rsp;
    t_rsp               rsp;

    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] nonempty_after;
    logic                  queue_empty;
    logic                  is_pop;
    logic                  push_ok;
    logic [LVL_W-1:0]      p_lvl;
    logic [TASK_W-1:0]     p_tidx;
    logic [TASK_W-1:0]     rd_tidx;
    logic [PC_W-1:0]       push_pc;
    logic [ORDER_W-1:0]    push_order;
    logic [ORDER_W-1:0]    new_act;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [TASK_FW-1:0]    rd_task;
    logic [PC_W-1:0]       rd_pc;
    logic [ORDER_W-1:0]    rd_order;

    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            nonempty[i]       = (r_count[i] != '0);
            nonempty_after[i] = nonempty[i] &&
                                !((LVL_W'(i) == r_top) && (r_count[i] == CNT_W'(1)));
        end
    end

    assign queue_empty = (nonempty == '0);
    assign is_pop      = r_req.kind[KIND_POP_BIT];
    assign p_lvl       = lvl_of(r_req.prio);
    assign p_tidx      = tidx_of(r_req.task_id);
    assign push_ok     = (32'(r_req.prio) < NUM_LEVELS) &&
                         (32'(r_req.task_id) < NUM_TASKS) &&
                         (32'(r_count[p_lvl]) < LEVEL_DEPTH);

    assign rd_task  = ram_rdata[ENTRY_W-1 -: TASK_FW];
    assign rd_pc    = ram_rdata[ORDER_W +: PC_W];
    assign rd_order = ram_rdata[ORDER_W-1:0];
    assign rd_tidx  = tidx_of(rd_task);

    // The head of the current top level is read while the request is captured.
    assign ram_raddr = slot_of(r_top, r_head[r_top]);

    assign new_act    = r_next_act[p_tidx] + ORDER_W'(1);
    assign push_pc    = (r_req.kind == KIND_PREEMPT) ? r_req.pc + PC_W'(1) : r_req.pc;
    assign push_order = (r_req.kind == KIND_PREEMPT) ? r_cur_act[p_tidx] : new_act;
    assign ram_waddr  = slot_of(p_lvl, r_tail[p_lvl]);
    assign ram_wdata  = {r_req.task_id, push_pc, push_order};

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_top      = r_top;
        n_next_act = r_next_act;
        n_cur_act  = r_cur_act;
        ram_we     = 1'b0;
        rsp        = '0;
        if (i_cmd.commit) begin
            if (is_pop) begin
                if (queue_empty) begin
                    rsp.status = r_req.sleepers_present ? ST_IDLE_TASK : ST_NONE;
                end else begin
                    if (32'(rd_task) < NUM_TASKS) begin
                        n_cur_act[rd_tidx] = rd_order;
                    end
                    n_head[r_top]      = ptr_inc(r_head[r_top]);
                    n_count[r_top]     = r_count[r_top] - CNT_W'(1);
                    n_top              = top_of(nonempty_after);
                    rsp.status         = ST_DISPATCHED;
                    rsp.out_task       = rd_task;
                    rsp.out_prio       = prio_of(r_top);
                    rsp.out_pc         = rd_pc;
                    rsp.out_activation = rd_order;
                end
            end else if (push_ok) begin
                ram_we         = 1'b1;
                n_tail[p_lvl]  = ptr_inc(r_tail[p_lvl]);
                n_count[p_lvl] = r_count[p_lvl] + CNT_W'(1);
                if (r_req.kind != KIND_PREEMPT) begin
                    n_next_act[p_tidx] = new_act;
                end
                if (p_lvl > r_top) begin
                    n_top = p_lvl;
                end
                rsp.status = ST_PUSHED;
            end else begin
                rsp.status = ST_FULL;
            end
            rsp.highest_ready = prio_of(n_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_next_act[i] <= '0;
                r_cur_act[i]  <= '0;
            end
            r_top <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_top      <= n_top;
            r_next_act <= n_next_act;
            r_cur_act  <= n_cur_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_rsp <= rsp;
        end
    end

    prq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_rsp                = r_rsp;
    assign o_status.queue_empty = queue_empty;
    // The tracked top level is non-empty whenever anything is queued.
    assign o_status.top_ok      = queue_empty || nonempty[r_top];
endmodule

// File: design/priority_ready_queue.sv
// Priority ready queue: one circular FIFO per level, highest non-empty level tracked.
// A request is accepted and captured together with the registered read of the queue RAM;
// its result is then committed to the result register, where it is held until taken.
// A new request is accepted only after the last one is committed; a stalled output
// holds the commit back.
// Reset (synchronous, active low) clears pointers, counts, top level and activation
// counters; the queue RAM is not cleared.
`include "priority_ready_queue_assert.svh"

module priority_ready_queue import prq_pkg::*; #(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
    parameter int NUM_TASKS   = DEF_NUM_TASKS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prq_stream_if.sink   i_req,
    prq_stream_if.source o_rsp
);
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;
    logic       out_valid;
    t_req       req_payload;
    t_rsp       rsp_payload;

    assign req_payload = i_req.payload;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd)
    );

    prq_datapath #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .NUM_TASKS   (NUM_TASKS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_req    (req_payload),
        .o_rsp    (rsp_payload),
        .o_status (dp_status)
    );

    assign i_req.ready   = in_ready;
    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = rsp_payload;

    `PRQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready,
                     !i_req.ready, "request accepted while one is in flight")
    `PRQ_ASSERT_ALWAYS(a_top_level_ok, i_clk, i_rst_n, dp_status.top_ok,
                       "tracked top level is empty while tasks are queued")
    `PRQ_ASSERT_IMPL(a_idle_means_empty, i_clk, i_rst_n,
                     o_rsp.valid && (o_rsp.payload.status == ST_IDLE_TASK ||
                                     o_rsp.payload.status == ST_NONE),
                     dp_status.queue_empty, "empty-queue result while tasks are queued")
    `PRQ_ASSERT_NEXT(a_commit_gives_result, i_clk, i_rst_n, dp_cmd.commit, o_rsp.valid,
                     "committed request produced no result")
endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the priority ready queue: random and directed requests are
// predicted by a local scheduler model and every result is checked in order.
// Depends on prq_pkg, prq_stream_if and priority_ready_queue.
module tb_top;
    import prq_pkg::*;

    localparam int NUM_ENTRIES   = DEF_NUM_LEVELS * DEF_LEVEL_DEPTH;
    localparam int PTR_W         = $clog2(DEF_LEVEL_DEPTH);
    localparam int CNT_W         = $clog2(DEF_LEVEL_DEPTH + 1);
    localparam int MAX_IDLE      = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int WRAP_TASK     = 9;
    localparam int WRAP_ROUNDS   = 260;

    localparam logic [KIND_W-1:0] KIND_POP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_ALT = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prq_stream_if #(.T(t_req)) req_if ();
    prq_stream_if #(.T(t_rsp)) rsp_if ();

    priority_ready_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Scheduler state as the block should hold it.
    logic [TASK_FW-1:0]  mem_task  [NUM_ENTRIES];
    logic [PC_W-1:0]     mem_pc    [NUM_ENTRIES];
    logic [ORDER_W-1:0]  mem_order [NUM_ENTRIES];
    logic [PTR_W-1:0]    q_head    [DEF_NUM_LEVELS];
    logic [PTR_W-1:0]    q_tail    [DEF_NUM_LEVELS];
    logic [CNT_W-1:0]    q_count   [DEF_NUM_LEVELS];
    logic [7:0]          q_total;
    logic [PRIO_FW-1:0]  q_top;
    logic [ORDER_W-1:0]  next_order [DEF_NUM_TASKS];
    logic [ORDER_W-1:0]  cur_order  [DEF_NUM_TASKS];
    logic [TASK_FW-1:0]  last_dispatched;

    t_rsp pending_rsp[$];
    int   fail_count = 0;
    int   cycle_count;
    bit   no_idle = 1'b0;
    bit   hold_rsp = 1'b0;

    // Task and level ranges are covered exactly by the field widths, so only a full
    // level can drop a push here.
    function automatic t_rsp schedule_step(input t_req r);
        t_rsp               rsp;
        int                 slot;
        logic [PRIO_FW-1:0] lvl;
        rsp = '0;
        if (r.kind[KIND_POP_BIT]) begin
            if (q_total == 0) begin
                rsp.status = r.sleepers_present ? ST_IDLE_TASK : ST_NONE;
            end else begin
                lvl  = q_top;
                slot = int'(lvl) * DEF_LEVEL_DEPTH + int'(q_head[lvl]);
                rsp.status         = ST_DISPATCHED;
                rsp.out_task       = mem_task[slot];
                rsp.out_prio       = lvl;
                rsp.out_pc         = mem_pc[slot];
                rsp.out_activation = mem_order[slot];
                cur_order[mem_task[slot]] = mem_order[slot];
                last_dispatched = mem_task[slot];
                q_head[lvl]  = q_head[lvl] + PTR_W'(1);
                q_count[lvl] = q_count[lvl] - CNT_W'(1);
                q_total      = q_total - 8'd1;
                while (q_top != 0 && q_count[q_top] == 0)
                    q_top = q_top - PRIO_FW'(1);
            end
        end else if (int'(q_count[r.prio]) >= DEF_LEVEL_DEPTH) begin
            rsp.status = ST_FULL;
        end else begin
            slot = int'(r.prio) * DEF_LEVEL_DEPTH + int'(q_tail[r.prio]);
            mem_task[slot] = r.task_id;
            if (r.kind == KIND_PREEMPT) begin
                mem_pc[slot]    = r.pc + PC_W'(1);
                mem_order[slot] = cur_order[r.task_id];
            end else begin
                next_order[r.task_id] = next_order[r.task_id] + ORDER_W'(1);
                mem_pc[slot]    = r.pc;
                mem_order[slot] = next_order[r.task_id];
            end
            q_tail[r.prio]  = q_tail[r.prio] + PTR_W'(1);
            q_count[r.prio] = q_count[r.prio] + CNT_W'(1);
            q_total         = q_total + 8'd1;
            if (r.prio > q_top)
                q_top = r.prio;
            rsp.status = ST_PUSHED;
        end
        rsp.highest_ready = q_top;
        return rsp;
    endfunction

    function automatic t_req sched_req(input logic [KIND_W-1:0] kind,
                                       input int task_id, input int prio,
                                       input logic [PC_W-1:0] pc, input bit sleepers);
        t_req r;
        r.kind             = kind;
        r.task_id          = task_id[TASK_FW-1:0];
        r.prio             = prio[PRIO_FW-1:0];
        r.pc               = pc;
        r.sleepers_present = sleepers;
        return r;
    endfunction

    // Pushes lean on one hot level so that levels fill up; most preempted pushes
    // re-queue the task that was dispatched last, as a scheduler would.
    function automatic t_req random_request(input int push_pct, input int hot_prio);
        int                 prio;
        int                 task_id;
        logic [PC_W-1:0]    pc;
        logic [KIND_W-1:0]  kind;
        prio = $urandom_range(0, 1) ? hot_prio : $urandom_range(0, DEF_NUM_LEVELS - 1);
        pc   = ($urandom_range(0, 7) == 0) ? '1 : PC_W'($urandom());
        if ($urandom_range(0, 99) < push_pct) begin
            kind = ($urandom_range(0, 2) == 0) ? KIND_PREEMPT : KIND_NEW;
            if (kind == KIND_PREEMPT && $urandom_range(0, 3) != 0)
                task_id = int'(last_dispatched);
            else
                task_id = $urandom_range(0, DEF_NUM_TASKS - 1);
        end else begin
            kind    = $urandom_range(0, 1) ? KIND_POP : KIND_POP_ALT;
            task_id = $urandom_range(0, DEF_NUM_TASKS - 1);
        end
        return sched_req(kind, task_id, prio, pc, 1'($urandom_range(0, 1)));
    endfunction

    // Valid stays high from one request to the next when there is no gap.
    task automatic send_request(input t_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        pending_rsp.push_back(schedule_step(r));
    endtask

    task automatic pop_until_empty();
        while (q_total != 0)
            send_request(sched_req(KIND_POP, 0, 0, '0, 1'($urandom_range(0, 1))));
    endtask

    task automatic test_empty_queue();
        send_request(sched_req(KIND_POP,     0, 0, '0, 1'b0));
        send_request(sched_req(KIND_POP_ALT, 0, 0, '0, 1'b1));
        send_request(sched_req(KIND_POP,     0, 0, '0, 1'b1));
        send_request(sched_req(KIND_POP_ALT, 0, 0, '0, 1'b0));
    endtask

    task automatic test_dispatch_extremes();
        send_request(sched_req(KIND_NEW, DEF_NUM_TASKS - 1, DEF_NUM_LEVELS - 1, '1, 1'b0));
        // A preempted pc of all ones wraps to zero.
        send_request(sched_req(KIND_PREEMPT, 0, 0, '1, 1'b1));
        send_request(sched_req(KIND_POP,     0, 0, '0, 1'b0));
        send_request(sched_req(KIND_POP_ALT, 0, 0, '0, 1'b1));
    endtask

    task automatic test_level_full();
        no_idle = 1'b1;
        for (int i = 0; i <= DEF_LEVEL_DEPTH; i++)
            send_request(sched_req(i[0] ? KIND_PREEMPT : KIND_NEW, i % DEF_NUM_TASKS, 4,
                                   PC_W'($urandom()), 1'b0));
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix(input int n_items);
        int push_pct;
        int hot_prio;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                push_pct = 25 * $urandom_range(1, 3);
                hot_prio = $urandom_range(0, DEF_NUM_LEVELS - 1);
                no_idle  = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request(push_pct, hot_prio));
        end
        no_idle = 1'b0;
    endtask

    // One task is activated often enough for its 8-bit activation order to wrap.
    task automatic test_activation_wrap();
        pop_until_empty();
        for (int i = 0; i < WRAP_ROUNDS; i++) begin
            send_request(sched_req(KIND_NEW, WRAP_TASK, $urandom_range(0, DEF_NUM_LEVELS - 1),
                                   PC_W'($urandom()), 1'($urandom_range(0, 1))));
            send_request(sched_req($urandom_range(0, 1) ? KIND_POP : KIND_POP_ALT, 0, 0, '0,
                                   1'($urandom_range(0, 1))));
            if ($urandom_range(0, 3) == 0) begin
                send_request(sched_req(KIND_PREEMPT, int'(last_dispatched),
                                       $urandom_range(0, DEF_NUM_LEVELS - 1),
                                       PC_W'($urandom()), 1'b0));
                send_request(sched_req(KIND_POP, 0, 0, '0, 1'b0));
            end
        end
    endtask

    task automatic test_fill_and_drain();
        no_idle = 1'b1;
        for (int i = 0; i < DEF_LEVEL_DEPTH + 2; i++) begin
            send_request(sched_req(KIND_NEW, $urandom_range(0, DEF_NUM_TASKS - 1), 0,
                                   PC_W'($urandom()), 1'b0));
            send_request(sched_req(KIND_NEW, $urandom_range(0, DEF_NUM_TASKS - 1),
                                   DEF_NUM_LEVELS - 1, PC_W'($urandom()), 1'b0));
        end
        pop_until_empty();
        send_request(sched_req(KIND_POP, 0, 0, '0, 1'b1));
        send_request(sched_req(KIND_POP, 0, 0, '0, 1'b0));
        no_idle = 1'b0;
    endtask

    // The receiver holds off while requests keep coming, so the block must stall its input.
    task automatic test_backpressure();
        hold_rsp = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(random_request(60, 2));
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    initial begin : rsp_checker
        t_rsp got;
        t_rsp want;
        int   stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
            got = rsp_if.payload;
            if (pending_rsp.size() == 0) begin
                $error("Result arrived with no request outstanding");
                fail_count++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("status",         16'(want.status),         16'(got.status));
                check_field("out_task",       16'(want.out_task),       16'(got.out_task));
                check_field("out_prio",       16'(want.out_prio),       16'(got.out_prio));
                check_field("out_pc",         16'(want.out_pc),         16'(got.out_pc));
                check_field("out_activation", 16'(want.out_activation),
                            16'(got.out_activation));
                check_field("highest_ready",  16'(want.highest_ready),  16'(got.highest_ready));
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        for (int l = 0; l < DEF_NUM_LEVELS; l++) begin
            q_head[l]  = '0;
            q_tail[l]  = '0;
            q_count[l] = '0;
        end
        for (int t = 0; t < DEF_NUM_TASKS; t++) begin
            next_order[t] = '0;
            cur_order[t]  = '0;
        end
        q_total         = '0;
        q_top           = '0;
        last_dispatched = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_dispatch_extremes();
        test_level_full();
        test_random_mix(350);
        test_activation_wrap();
        test_fill_and_drain();
        test_backpressure();

        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
